>>> hdl/cflk_pkg.sv
// cflk_pkg: shared types and constants of the candle flicker generator
// no dependencies; imported by cflk_cfg, cflk_step and the top level
`timescale 1ns / 1ps

package cflk_pkg;

  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  // register byte addresses
  localparam logic [PaddrWidth-1:0] AddrDarkThreshold = 3'd0;

  localparam logic [7:0]  DarkThresholdReset = 8'd176;
  localparam logic [15:0] LfsrReset          = 16'h5AD3;
  localparam logic [7:0]  GoalReset          = 8'd127;
  localparam logic [7:0]  IntervalReset      = 8'd127;
  localparam logic [4:0]  BurstReset         = 5'd2;

  localparam logic [7:0]  GoalLow       = 8'd96;
  localparam logic [7:0]  GoalRecover   = 8'd128;
  localparam logic [7:0]  HighGoalBase  = 8'd160;  // 224 - 2*32, mod 256
  localparam logic [7:0]  QuietGoalMax  = 8'd16;
  localparam logic [7:0]  QuietMin      = 8'd8;
  localparam logic [7:0]  BurstInterval = 8'd5;
  localparam logic [4:0]  BurstFloor    = 5'h08;
  localparam logic [7:0]  IntervalFloor = 8'h20;

  typedef struct packed {
    logic [15:0] lfsr;
    logic [7:0]  level;
    logic [7:0]  second_level;
    logic [7:0]  goal;
    logic [7:0]  interval;
    logic [4:0]  burst_count;
    logic [7:0]  quiet_count;
    logic        recovering;
  } flick_state_t;

  localparam flick_state_t StateReset = '{
    lfsr:         LfsrReset,
    level:        8'd0,
    second_level: 8'd0,
    goal:         GoalReset,
    interval:     IntervalReset,
    burst_count:  BurstReset,
    quiet_count:  8'd0,
    recovering:   1'b0
  };

endpackage

>>> hdl/candle_flicker_generator_core.sv
// candle_flicker_generator_core: two-stage candle flicker pipeline
// result passes through the input register and then the state/result register around
// cflk_step; throughput 1 item per cycle while out_stall_i is low
// reset: flicker state and threshold (176) set to reset values, valid flags cleared asynchronously
// depends on cflk_pkg, cflk_cfg, cflk_step
`timescale 1ns / 1ps

module candle_flicker_generator_core
  import cflk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            ambient_level_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            left_duty_o,
  output logic [7:0]            right_duty_o,
  output logic [7:0]            step_length_o,
  output logic                  outputs_enabled_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  logic [7:0]   dark_threshold;
  flick_state_t state_q, state_d;
  logic         en_comb;

  // input register stage
  logic         in_vld_q;
  logic [7:0]   amb_q;

  // result register stage
  logic         out_vld_q;
  logic [7:0]   left_q, right_q, len_q;
  logic         en_q;

  logic         advance;   // input stage item moves into result register
  logic         in_take;

  cflk_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .dark_threshold_o (dark_threshold)
  );

  cflk_step u_step (
    .cur_i            (state_q),
    .ambient_level_i  (amb_q),
    .dark_threshold_i (dark_threshold),
    .nxt_o            (state_d),
    .enabled_o        (en_comb)
  );

  // result register frees when empty or being taken this cycle
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  // input register can refill whenever it is empty or draining
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateReset;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end

      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;   // state commits as the result is produced
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      amb_q <= ambient_level_i;
    end
    if (advance) begin
      left_q  <= state_d.level;
      right_q <= state_d.second_level;
      len_q   <= state_d.interval;
      en_q    <= en_comb;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign left_duty_o       = left_q;
  assign right_duty_o      = right_q;
  assign step_length_o     = len_q;
  assign outputs_enabled_o = en_q;

endmodule

>>> hdl/cflk_cfg.sv
// cflk_cfg: apb register block holding the dark threshold
// depends on cflk_pkg
`timescale 1ns / 1ps

module cflk_cfg
  import cflk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready,
  output logic [7:0]            dark_threshold_o
);

  logic [7:0] thresh_q, thresh_d;
  logic       sel_thresh;

  assign pready     = 1'b1;
  // low address bits are ignored, one word per register
  assign sel_thresh = (paddr[PaddrWidth-1:2] == AddrDarkThreshold[PaddrWidth-1:2]);

  always_comb begin
    thresh_d = thresh_q;
    if (psel && penable && pwrite && pready && sel_thresh) begin
      thresh_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= DarkThresholdReset;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  assign prdata           = sel_thresh ? {{(PdataWidth-8){1'b0}}, thresh_q} : '0;
  assign dark_threshold_o = thresh_q;

endmodule

>>> hdl/cflk_step.sv
// cflk_step: next-state logic of one flicker tick (goal draw, ramp, duties)
// depends on cflk_pkg
`timescale 1ns / 1ps

module cflk_step
  import cflk_pkg::*;
(
  input  flick_state_t cur_i,
  input  logic [7:0]   ambient_level_i,
  input  logic [7:0]   dark_threshold_i,
  output flick_state_t nxt_o,
  output logic         enabled_o
);

  flick_state_t drawn;
  logic [4:0]   bc_dec;
  logic         fb;
  logic [15:0]  lfsr_nx;

  always_comb begin
    drawn   = cur_i;
    bc_dec  = cur_i.burst_count - 5'd1;
    fb      = cur_i.lfsr[1] ^ cur_i.lfsr[2];
    lfsr_nx = {fb, cur_i.lfsr[15:1]};

    if (cur_i.level == cur_i.goal) begin
      if (cur_i.burst_count != 5'd0) begin
        // oscillation burst
        drawn.burst_count = bc_dec;
        drawn.recovering  = 1'b0;
        if (bc_dec < 5'd2) begin
          drawn.goal = GoalRecover;
        end else if (bc_dec[0]) begin
          drawn.goal = GoalLow;
        end else begin
          drawn.goal     = HighGoalBase + {2'b00, bc_dec, 1'b0};
          drawn.interval = cur_i.interval + 8'd1;
        end
      end else begin
        drawn.lfsr = lfsr_nx;
        if ((lfsr_nx[7:0] < QuietGoalMax) && (cur_i.quiet_count > QuietMin)) begin
          drawn.burst_count = lfsr_nx[12:8] | BurstFloor;
          drawn.interval    = BurstInterval;
          drawn.goal        = GoalRecover;
          drawn.quiet_count = 8'd0;
          drawn.recovering  = 1'b1;
        end else begin
          drawn.goal        = lfsr_nx[7:0];
          drawn.interval    = {1'b0, lfsr_nx[14:8]} | IntervalFloor;
          drawn.quiet_count = cur_i.quiet_count + 8'd1;
        end
      end
    end

    // ramp by one; equal goal still steps down
    if (cur_i.level < drawn.goal) begin
      drawn.level = cur_i.level + 8'd1;
    end else begin
      drawn.level = cur_i.level - 8'd1;
    end

    if ((drawn.burst_count != 5'd0) && !drawn.recovering) begin
      drawn.second_level = drawn.level;
    end else begin
      drawn.second_level = ~drawn.level;
    end

    enabled_o = (ambient_level_i <= dark_threshold_i);
    nxt_o     = enabled_o ? drawn : cur_i;
  end

endmodule
